// File: rtl/soa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slab object allocator package
// shared types, constants and helper functions
// ----------------------------------------------------------------------------
package soa_pkg;

    localparam int POOL_PAGES   = 16;
    localparam int PAGE_BYTES   = 4096;
    localparam int SIZE_CLASSES = 8;
    localparam int HEADER_BYTES = 32;

    localparam int SLOTS_PER_PAGE = PAGE_BYTES / 8;
    localparam int SLOT_W         = $clog2(SLOTS_PER_PAGE);
    localparam int PG_W           = 4;
    localparam int LINK_W         = 5;
    localparam int CLS_W          = 3;
    localparam int CNT_W          = 9;
    localparam logic [LINK_W-1:0] LIST_EMPTY = 5'd16;
    localparam logic [11:0]       OFFSET_MASK = 12'hfff;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_LARGE   = 3'd1,
        ST_NO_PAGE     = 3'd2,
        ST_MISALIGNED  = 3'd3,
        ST_UNUSED_PAGE = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_FIND,
        S_BUILD,
        S_TAKE_RD,
        S_TAKE_WR,
        S_FREE_CHK,
        S_FREE_WR,
        S_UNLINK,
        S_DONE
    } t_state;

    // controller -> datapath commands
    typedef struct packed {
        logic load;
        logic decode;
        logic walk_step;
        logic find;
        logic build_start;
        logic build_step;
        logic take_rd;
        logic take_wr;
        logic free_chk;
        logic free_wr;
        logic unlink_start;
        logic unlink_step;
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic is_free;
        logic err;
        logic walk_hit;
        logic walk_end;
        logic no_page;
        logic build_last;
        logic reclaim;
        logic unlink_end;
    } t_sts;

    function automatic logic [CNT_W-1:0] slot_count(input logic [CLS_W-1:0] cls,
                                                    input logic [11:0] hdr);
        logic [12:0] n;
        n = (13'(PAGE_BYTES) - {1'b0, hdr}) >> ({1'b0, cls} + 4'd3);
        return n[CNT_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/soa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slab object allocator controller
// sequences each request through the datapath
// ----------------------------------------------------------------------------
module soa_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    output logic               o_res_valid,
    input  wire                i_res_taken,
    input  wire soa_pkg::t_sts i_sts,
    output soa_pkg::t_cmd      o_cmd
);

    soa_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= soa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            soa_pkg::S_IDLE:     if (i_in_valid) n_state = soa_pkg::S_DECODE;
            soa_pkg::S_DECODE: begin
                if (i_sts.is_free) n_state = soa_pkg::S_FREE_CHK;
                else if (i_sts.err) n_state = soa_pkg::S_DONE;
                else n_state = soa_pkg::S_WALK;
            end
            soa_pkg::S_WALK: begin
                if (i_sts.walk_hit) n_state = soa_pkg::S_TAKE_RD;
                else if (i_sts.walk_end) n_state = soa_pkg::S_FIND;
            end
            soa_pkg::S_FIND: begin
                if (i_sts.no_page) n_state = soa_pkg::S_DONE;
                else n_state = soa_pkg::S_BUILD;
            end
            soa_pkg::S_BUILD:    if (i_sts.build_last) n_state = soa_pkg::S_TAKE_RD;
            soa_pkg::S_TAKE_RD:  n_state = soa_pkg::S_TAKE_WR;
            soa_pkg::S_TAKE_WR:  n_state = soa_pkg::S_DONE;
            soa_pkg::S_FREE_CHK: begin
                if (i_sts.err) n_state = soa_pkg::S_DONE;
                else n_state = soa_pkg::S_FREE_WR;
            end
            soa_pkg::S_FREE_WR: begin
                if (i_sts.reclaim) n_state = soa_pkg::S_UNLINK;
                else n_state = soa_pkg::S_DONE;
            end
            soa_pkg::S_UNLINK:   if (i_sts.unlink_end) n_state = soa_pkg::S_DONE;
            soa_pkg::S_DONE:     if (i_res_taken) n_state = soa_pkg::S_IDLE;
            default:             n_state = soa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            soa_pkg::S_IDLE: begin
                // no beat is taken while reset is held
                o_in_ready = i_rst_n;
                o_cmd.load = i_in_valid;
            end
            soa_pkg::S_DECODE:   o_cmd.decode = 1'b1;
            soa_pkg::S_WALK:     o_cmd.walk_step = 1'b1;
            soa_pkg::S_FIND: begin
                o_cmd.find        = 1'b1;
                o_cmd.build_start = !i_sts.no_page;
            end
            soa_pkg::S_BUILD:    o_cmd.build_step = 1'b1;
            soa_pkg::S_TAKE_RD:  o_cmd.take_rd = 1'b1;
            soa_pkg::S_TAKE_WR:  o_cmd.take_wr = 1'b1;
            soa_pkg::S_FREE_CHK: o_cmd.free_chk = 1'b1;
            soa_pkg::S_FREE_WR: begin
                o_cmd.free_wr      = 1'b1;
                o_cmd.unlink_start = 1'b1;
            end
            soa_pkg::S_UNLINK:   o_cmd.unlink_step = 1'b1;
            soa_pkg::S_DONE:     o_res_valid = 1'b1;
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_res_valid)
        else $error("ready while result pending");
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_taken) |=> o_res_valid)
        else $error("result dropped");
    a_take_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take_rd |=> o_cmd.take_wr)
        else $error("take sequence broken");
`endif

endmodule
`default_nettype wire

// File: rtl/soa_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slab object allocator datapath
// page tables, slot link memory and request registers
// ----------------------------------------------------------------------------
module soa_datapath #(
    parameter int POOL_PAGES   = soa_pkg::POOL_PAGES,
    parameter int SIZE_CLASSES = soa_pkg::SIZE_CLASSES,
    parameter int HEADER_BYTES = soa_pkg::HEADER_BYTES
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire soa_pkg::t_cmd   i_cmd,
    output soa_pkg::t_sts        o_sts,
    input  wire                  i_func,
    input  wire [31:0]           i_req_size,
    input  wire [15:0]           i_free_addr,
    output logic [2:0]           o_status,
    output logic [15:0]          o_obj_addr
);

    localparam int SW = soa_pkg::SLOT_W;
    localparam int PW = soa_pkg::PG_W;
    localparam int LW = soa_pkg::LINK_W;
    localparam int CW = soa_pkg::CLS_W;
    localparam int NW = soa_pkg::CNT_W;
    localparam logic [11:0] HDR = 12'(HEADER_BYTES);

    logic [LW-1:0] r_class_head [SIZE_CLASSES];
    logic          r_in_use [POOL_PAGES];
    logic [CW-1:0] r_pclass [POOL_PAGES];
    logic [NW-1:0] r_pcount [POOL_PAGES];
    logic [SW-1:0] r_phead [POOL_PAGES];
    logic [LW-1:0] r_pnext [POOL_PAGES];
    logic [SW-1:0] r_slot_mem [POOL_PAGES * soa_pkg::SLOTS_PER_PAGE];

    logic          r_func;
    logic [31:0]   r_size;
    logic [15:0]   r_faddr;
    logic [3:0]    r_cls_full;
    logic [CW-1:0] r_cls;
    logic [LW-1:0] r_cur;
    logic [PW-1:0] r_pg;
    logic [4:0]    r_k;
    logic [NW-1:0] r_bi;
    logic [NW-1:0] r_bn;
    logic [SW-1:0] r_slot;
    logic [SW-1:0] r_rd;
    logic [2:0]    r_status;
    logic [15:0]   r_addr;

    // bit length of size >> 3, capped at 15
    logic [3:0] w_blen;
    always_comb begin
        w_blen = 4'd0;
        for (int b = 0; b < 29; b++) begin
            if (r_size[b+3]) w_blen = (b + 1 > 15) ? 4'd15 : 4'(b + 1);
        end
    end

    // lowest free page
    logic [PW-1:0] w_free_pg;
    logic          w_any_free;
    always_comb begin
        w_free_pg  = '0;
        w_any_free = 1'b0;
        for (int p = POOL_PAGES - 1; p >= 0; p--) begin
            if (!r_in_use[p]) begin
                w_free_pg  = PW'(p);
                w_any_free = 1'b1;
            end
        end
    end

    logic [PW-1:0] w_cur_pg;
    logic          w_cur_ok;
    assign w_cur_pg = r_cur[PW-1:0];
    assign w_cur_ok = (r_cur < LW'(POOL_PAGES));

    // free address decode
    logic [PW-1:0] w_fpg;
    logic [11:0]   w_off;
    logic [11:0]   w_rel;
    logic [CW-1:0] w_fcls;
    logic [11:0]   w_fmask;
    logic [11:0]   w_fslot;
    logic          w_fpg_ok;
    assign w_fpg    = i_free_addr[15:12] & 4'hf;
    assign w_fpg_ok = (5'(r_faddr[15:12]) < LW'(POOL_PAGES)) && r_in_use[r_faddr[15:12]];
    assign w_off    = r_faddr[11:0] & soa_pkg::OFFSET_MASK;
    assign w_rel    = w_off - HDR;
    assign w_fcls   = r_pclass[r_faddr[15:12]];
    assign w_fmask  = (12'd8 << w_fcls) - 12'd1;
    assign w_fslot  = w_rel >> ({1'b0, w_fcls} + 4'd3);

    logic [NW-1:0] w_cnt_inc;
    assign w_cnt_inc = r_pcount[r_pg] + NW'(1);

    always_comb begin
        o_sts            = '0;
        o_sts.is_free    = r_func;
        o_sts.err        = r_func ? (!w_fpg_ok || w_off < HDR || (w_rel & w_fmask) != 0
                                     || w_fslot >= 12'(soa_pkg::slot_count(w_fcls, HDR)))
                                  : (w_blen >= 4'(SIZE_CLASSES));
        o_sts.walk_hit   = w_cur_ok && (r_pcount[w_cur_pg] != '0) && (r_k < 5'(POOL_PAGES));
        o_sts.walk_end   = !w_cur_ok || (r_k >= 5'(POOL_PAGES));
        o_sts.no_page    = !w_any_free;
        o_sts.build_last = (r_bi + NW'(1) >= r_bn);
        o_sts.reclaim    = (w_cnt_inc >= soa_pkg::slot_count(r_pclass[r_pg], HDR));
        o_sts.unlink_end = (r_cur == 5'(r_pg)) || !w_cur_ok || (r_k >= 5'(POOL_PAGES))
                           || (r_pnext[w_cur_pg] == 5'(r_pg));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < SIZE_CLASSES; c++) r_class_head[c] <= soa_pkg::LIST_EMPTY;
            for (int p = 0; p < POOL_PAGES; p++) r_in_use[p] <= 1'b0;
        end else begin
            if (i_cmd.build_start) begin
                r_in_use[w_free_pg]  <= 1'b1;
                r_pclass[w_free_pg]  <= r_cls;
                r_pcount[w_free_pg]  <= soa_pkg::slot_count(r_cls, HDR);
                r_phead[w_free_pg]   <= '0;
                r_pnext[w_free_pg]   <= r_class_head[r_cls];
                r_class_head[r_cls]  <= 5'(w_free_pg);
            end
            if (i_cmd.take_wr) begin
                r_phead[r_pg]  <= r_rd;
                r_pcount[r_pg] <= r_pcount[r_pg] - NW'(1);
            end
            if (i_cmd.free_wr) begin
                r_phead[r_pg]  <= r_slot;
                r_pcount[r_pg] <= w_cnt_inc;
                if (o_sts.reclaim) r_in_use[r_pg] <= 1'b0;
            end
            if (i_cmd.unlink_step) begin
                if (r_cur == 5'(r_pg)) begin
                    r_class_head[r_pclass[r_pg]] <= r_pnext[r_pg];
                end else if (w_cur_ok && r_k < 5'(POOL_PAGES)
                             && r_pnext[w_cur_pg] == 5'(r_pg)) begin
                    r_pnext[w_cur_pg] <= r_pnext[r_pg];
                end
            end
        end
    end

    // slot link memory: one write or read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.build_step) begin
            r_slot_mem[{r_pg, r_bi[SW-1:0]}] <=
                (r_bi + NW'(1) < r_bn) ? SW'(r_bi + NW'(1)) : '0;
        end else if (i_cmd.free_wr) begin
            r_slot_mem[{r_pg, r_slot}] <= r_phead[r_pg];
        end
        if (i_cmd.take_rd) r_rd <= r_slot_mem[{r_pg, r_phead[r_pg]}];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= i_func;
            r_size   <= i_req_size;
            r_faddr  <= i_free_addr;
            r_pg     <= w_fpg;
            r_status <= soa_pkg::ST_OK;
            r_addr   <= '0;
        end
        if (i_cmd.decode) begin
            r_cls_full <= w_blen;
            r_cls      <= w_blen[CW-1:0];
            if (!r_func) begin
                r_cur <= r_class_head[w_blen[CW-1:0]];
                if (w_blen >= 4'(SIZE_CLASSES)) r_status <= soa_pkg::ST_TOO_LARGE;
            end
            r_k <= '0;
        end
        if (i_cmd.walk_step) begin
            if (o_sts.walk_hit) r_pg <= w_cur_pg;
            else if (!o_sts.walk_end) begin
                r_cur <= r_pnext[w_cur_pg];
                r_k   <= r_k + 5'd1;
            end
        end
        if (i_cmd.find) begin
            if (!w_any_free) r_status <= soa_pkg::ST_NO_PAGE;
            r_pg <= w_free_pg;
            r_bi <= '0;
            r_bn <= soa_pkg::slot_count(r_cls, HDR);
        end
        if (i_cmd.build_step) r_bi <= r_bi + NW'(1);
        if (i_cmd.take_rd) r_slot <= r_phead[r_pg];
        if (i_cmd.take_wr) begin
            r_addr <= 16'({r_pg, 12'd0}) + 16'(HDR)
                      + 16'(({7'd0, r_slot} << ({1'b0, r_cls} + 4'd3)));
        end
        if (i_cmd.free_chk) begin
            r_slot <= w_fslot[SW-1:0];
            if (!w_fpg_ok) r_status <= soa_pkg::ST_UNUSED_PAGE;
            else if (o_sts.err) r_status <= soa_pkg::ST_MISALIGNED;
        end
        if (i_cmd.unlink_start) begin
            r_cur <= r_class_head[r_pclass[r_pg]];
            r_k   <= '0;
        end
        if (i_cmd.unlink_step) begin
            if (r_cur != 5'(r_pg) && w_cur_ok) begin
                r_cur <= r_pnext[w_cur_pg];
                r_k   <= r_k + 5'd1;
            end
        end
    end

    assign o_status   = r_status;
    assign o_obj_addr = (r_status == soa_pkg::ST_OK && !r_func && r_cls_full < 4'(SIZE_CLASSES))
                        ? r_addr : 16'd0;

`ifndef ASSERT_OFF
    a_build_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.build_step |-> (r_bi < r_bn))
        else $error("slab build overrun");
    a_take_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_wr |-> (r_pcount[r_pg] != '0))
        else $error("take from empty slab");
    a_link_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk_step |-> (r_k <= 5'(POOL_PAGES)))
        else $error("list walk too long");
`endif

endmodule
`default_nettype wire

// File: rtl/slab_object_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slab object allocator core
// power-of-two slab allocator over a fixed page pool
// ----------------------------------------------------------------------------
// channel   dir  tuser      tdata fields (lsb first)
// s_axis    in   func       req_size[31:0], free_addr[47:32]
// m_axis    out  -          status[2:0], obj_addr[18:3], pad to 24
//
// one request at a time: an alloc decodes the size, walks the class list for a
// slab with a free slot (up to POOL_PAGES entries), then takes the slab's head
// slot; a new slab adds a find step and a build step per slot, and a size too
// large ends after decode. a free decodes, checks and writes the slot (a bad
// free ends after the check); a reclaim adds unlink steps that walk to the page
// in its class list. ready is low from accept until the result beat is taken.
// synchronous active-low reset empties every class list.
// ----------------------------------------------------------------------------
module slab_object_allocator_core #(
    parameter int POOL_PAGES   = soa_pkg::POOL_PAGES,
    parameter int SIZE_CLASSES = soa_pkg::SIZE_CLASSES,
    parameter int HEADER_BYTES = soa_pkg::HEADER_BYTES
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire        s_axis_tuser,   // func
    input  wire [47:0] s_axis_tdata,   // req_size, free_addr
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [23:0] m_axis_tdata   // status, obj_addr
);

    soa_pkg::t_cmd w_cmd;
    soa_pkg::t_sts w_sts;
    logic [2:0]    w_status;
    logic [15:0]   w_addr;

    soa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_res_valid (m_axis_tvalid),
        .i_res_taken (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    soa_datapath #(
        .POOL_PAGES   (POOL_PAGES),
        .SIZE_CLASSES (SIZE_CLASSES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_func      (s_axis_tuser),
        .i_req_size  (s_axis_tdata[31:0]),
        .i_free_addr (s_axis_tdata[47:32]),
        .o_status    (w_status),
        .o_obj_addr  (w_addr)
    );

    assign m_axis_tdata = {5'd0, w_addr, w_status};

endmodule
`default_nettype wire

// File: tb/slab_object_allocator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab object allocator core testbench
// drives alloc/free requests in bursts, predicts status and object address
// from a behavioral allocator model and checks each result beat in order
// ----------------------------------------------------------------------------
module slab_object_allocator_core_tb;

    typedef struct packed {
        logic        func;
        logic [31:0] req_size;
        logic [15:0] free_addr;
    } t_req;

    typedef struct packed {
        soa_pkg::t_status status;
        logic [15:0]      obj_addr;
    } t_res;

    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;
    localparam int   SPP      = soa_pkg::SLOTS_PER_PAGE;
    localparam int   NSLOT    = soa_pkg::POOL_PAGES * SPP;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic        s_axis_tuser;   // func
    logic [47:0] s_axis_tdata;   // req_size, free_addr
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // status, obj_addr

    slab_object_allocator_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // allocator model state
    logic [4:0] mdl_head [soa_pkg::SIZE_CLASSES];
    logic       mdl_used [soa_pkg::POOL_PAGES];
    logic [2:0] mdl_cls  [soa_pkg::POOL_PAGES];
    logic [8:0] mdl_cnt  [soa_pkg::POOL_PAGES];
    logic [8:0] mdl_fhd  [soa_pkg::POOL_PAGES];
    logic [4:0] mdl_nxt  [soa_pkg::POOL_PAGES];
    logic [8:0] mdl_link [NSLOT];

    t_req pending_reqs[$];
    t_res expected_res[$];
    logic [15:0] live_objs[$];
    int   n_err;
    int   n_items;
    int   n_seen;
    t_req acc_req;

    function automatic int slots_of(int c);
        return (soa_pkg::PAGE_BYTES - soa_pkg::HEADER_BYTES) / (8 << c);
    endfunction

    task automatic mdl_clear();
        for (int i = 0; i < soa_pkg::SIZE_CLASSES; i++) mdl_head[i] = soa_pkg::LIST_EMPTY;
        for (int i = 0; i < soa_pkg::POOL_PAGES; i++) begin
            mdl_used[i] = 0; mdl_cls[i] = 0; mdl_cnt[i] = 0;
            mdl_fhd[i] = 0; mdl_nxt[i] = 0;
        end
        for (int i = 0; i < NSLOT; i++) mdl_link[i] = 0;
    endtask

    function automatic t_res alloc_free_predict(t_req r);
        t_res o;
        int v, c, cur, pg, k, n, slot, off, s;
        o.status = soa_pkg::ST_OK;
        o.obj_addr = '0;
        pg = soa_pkg::POOL_PAGES;
        if (r.func == FN_ALLOC) begin
            v = int'(r.req_size >> 3);
            c = 0;
            while (v != 0) begin
                v = v >> 1;
                c++;
            end
            if (c >= soa_pkg::SIZE_CLASSES) begin
                o.status = soa_pkg::ST_TOO_LARGE;
                return o;
            end
            cur = int'(mdl_head[c]);
            for (k = 0; k < soa_pkg::POOL_PAGES && cur < soa_pkg::POOL_PAGES; k++) begin
                if (mdl_cnt[cur] != 0) begin
                    pg = cur;
                    break;
                end
                cur = int'(mdl_nxt[cur]);
            end
            if (pg == soa_pkg::POOL_PAGES) begin
                for (k = 0; k < soa_pkg::POOL_PAGES; k++)
                    if (!mdl_used[k]) begin
                        pg = k;
                        break;
                    end
                if (pg == soa_pkg::POOL_PAGES) begin
                    o.status = soa_pkg::ST_NO_PAGE;
                    return o;
                end
                n = slots_of(c);
                mdl_used[pg] = 1'b1;
                mdl_cls[pg] = 3'(c);
                mdl_cnt[pg] = 9'(n);
                mdl_fhd[pg] = '0;
                for (k = 0; k < n; k++)
                    mdl_link[pg*SPP + k] = 9'((k + 1 < n) ? k + 1 : 0);
                mdl_nxt[pg] = mdl_head[c];
                mdl_head[c] = 5'(pg);
            end
            slot = int'(mdl_fhd[pg]);
            mdl_fhd[pg] = mdl_link[pg*SPP + slot];
            mdl_cnt[pg] = mdl_cnt[pg] - 9'd1;
            o.obj_addr = 16'(pg * soa_pkg::PAGE_BYTES + soa_pkg::HEADER_BYTES
                             + slot * (8 << c));
            return o;
        end
        pg = int'(r.free_addr) / soa_pkg::PAGE_BYTES;
        off = int'(r.free_addr & 16'hfff);
        if (pg >= soa_pkg::POOL_PAGES || !mdl_used[pg]) begin
            o.status = soa_pkg::ST_UNUSED_PAGE;
            return o;
        end
        c = int'(mdl_cls[pg]);
        s = 8 << c;
        if (off < soa_pkg::HEADER_BYTES || ((off - soa_pkg::HEADER_BYTES) % s) != 0 ||
            (off - soa_pkg::HEADER_BYTES) / s >= slots_of(c)) begin
            o.status = soa_pkg::ST_MISALIGNED;
            return o;
        end
        slot = (off - soa_pkg::HEADER_BYTES) / s;
        mdl_link[pg*SPP + slot] = mdl_fhd[pg];
        mdl_fhd[pg] = 9'(slot);
        mdl_cnt[pg] = mdl_cnt[pg] + 9'd1;
        if (int'(mdl_cnt[pg]) >= slots_of(c)) begin
            // reclaim: unlink the page from its class list
            cur = int'(mdl_head[c]);
            if (cur == pg) mdl_head[c] = mdl_nxt[pg];
            else begin
                for (k = 0; k < soa_pkg::POOL_PAGES && cur < soa_pkg::POOL_PAGES; k++) begin
                    if (int'(mdl_nxt[cur]) == pg) begin
                        mdl_nxt[cur] = mdl_nxt[pg];
                        break;
                    end
                    cur = int'(mdl_nxt[cur]);
                end
            end
            mdl_used[pg] = 1'b0;
        end
        return o;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        n_err++;
    endtask

    // queue a request and track the objects it hands out
    task automatic push_req(input t_req r);
        t_res p;
        pending_reqs.push_back(r);
        p = alloc_free_predict(r);
        if (r.func == FN_ALLOC && p.status == soa_pkg::ST_OK) live_objs.push_back(p.obj_addr);
    endtask

    // driver: bursts with random gaps
    int burst_left, gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) void'(pending_reqs.pop_front());
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= pending_reqs[0].func;
                s_axis_tdata <= {pending_reqs[0].free_addr, pending_reqs[0].req_size};
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end else burst_left <= burst_left - 1;
            end else s_axis_tvalid <= 1'b0;
        end
    end

    // predict at input acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            acc_req.func = s_axis_tuser;
            acc_req.req_size = s_axis_tdata[31:0];
            acc_req.free_addr = s_axis_tdata[47:32];
            expected_res.push_back(alloc_free_predict(acc_req));
        end
    end

    // receiver stall pattern, with one long hold-off
    int  stall_phase;
    int  hold_left;
    bit  held;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_phase <= 0;
            hold_left <= 0;
            held <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!held && pending_reqs.size() < 700 && pending_reqs.size() > 0) begin
            held <= 1'b1;
            hold_left <= 400;
            m_axis_tready <= 1'b0;
        end else begin
            stall_phase <= (stall_phase + 1) % 37;
            if (stall_phase < 12) m_axis_tready <= 1'b1;
            else m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor
    t_res got, want;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = soa_pkg::t_status'(m_axis_tdata[2:0]);
            got.obj_addr = m_axis_tdata[18:3];
            n_seen++;
            if (expected_res.size() == 0) begin
                report_mismatch("extra beat", 1, 0);
            end else begin
                want = expected_res.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.obj_addr != want.obj_addr)
                    report_mismatch("obj_addr", got.obj_addr, want.obj_addr);
            end
        end
    end

    function automatic t_req mk_alloc(logic [31:0] sz);
        t_req r;
        r.func = FN_ALLOC;
        r.req_size = sz;
        r.free_addr = 16'($urandom);
        return r;
    endfunction

    function automatic t_req mk_free(logic [15:0] a);
        t_req r;
        r.func = FN_FREE;
        r.req_size = $urandom;
        r.free_addr = a;
        return r;
    endfunction

    initial begin
        int i, c, j, a;
        n_err = 0;
        n_seen = 0;
        n_items = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        mdl_clear();

        // directed: size extremes, class edges, error frees
        push_req(mk_free(16'h0000));      // unused page
        push_req(mk_free(16'hffff));
        push_req(mk_alloc(32'd0));
        push_req(mk_alloc(32'd7));
        push_req(mk_alloc(32'd8));        // power of two goes up
        push_req(mk_alloc(32'd511));
        push_req(mk_alloc(32'd512));      // largest class (1024-byte objects)
        push_req(mk_alloc(32'hffffffff));
        push_req(mk_alloc(32'h80000000));
        push_req(mk_free(16'h0000));      // inside header
        push_req(mk_free(16'h0021));      // not on slot boundary
        push_req(mk_free(16'h0020));      // ok
        push_req(mk_free(16'h0020));      // double free
        push_req(mk_free(16'h1ff8));      // past last slot candidate
        push_req(mk_free(16'hf020));
        // big objects: 7 per page
        for (i = 0; i < 8; i++) push_req(mk_alloc(32'd300));
        // random part
        for (i = 0; i < 700; i++) begin
            c = $urandom_range(0, 99);
            if (c < 45) push_req(mk_alloc($urandom_range(0, 511)));
            else if (c < 50) push_req(mk_alloc($urandom));
            else if (c < 60) push_req(mk_free(16'($urandom)));
            else if (c < 65) begin
                a = 32 + 8 * $urandom_range(0, 8);
                push_req(mk_free(16'($urandom_range(0, 15) * soa_pkg::PAGE_BYTES + a)));
            end else begin
                // free a previously returned object
                if (live_objs.size() > 0) begin
                    j = $urandom_range(0, live_objs.size() - 1);
                    push_req(mk_free(live_objs[j]));
                    live_objs.delete(j);
                end else push_req(mk_alloc($urandom_range(0, 300)));
            end
            // burst of heavy allocation now and then to reach exhaustion
            if (i % 250 == 100)
                for (j = 0; j < 120; j++) push_req(mk_alloc(32'd300));
        end
        n_items = pending_reqs.size();
        mdl_clear();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (n_seen >= n_items);
        repeat (20) @(posedge i_clk);
        if (expected_res.size() != 0) report_mismatch("missing beats", expected_res.size(), 0);
        if (n_err == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/soa_pkg.sv
rtl/soa_ctrl.sv
rtl/soa_datapath.sv
rtl/slab_object_allocator_core.sv
tb/slab_object_allocator_core_tb.sv
